// ----- design/mbps_pkg.sv -----
package mbps_pkg;

  // default and upper bound of the signature length
  localparam int PATTERN_MAX_DEF = 48;

  // configuration register map
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int NUM_PAT_REGS = 6;
  localparam int CARE_W      = 48;
  localparam int LEN_W       = 6;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LAST  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CARE      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEN       = 3'd7;

  localparam logic [CARE_W-1:0] CARE_RESET = {CARE_W{1'b1}};
  localparam logic [LEN_W-1:0]  LEN_RESET  = 6'd1;

  // region byte counter and reported offset
  localparam int SEEN_W   = 33;
  localparam int OFFSET_W = 32;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                match_found;
    logic [OFFSET_W-1:0] match_offset;
  } out_t;

  // per-cycle control shared by every cell of the chain
  typedef struct packed {
    logic advance;     // a byte is taken this cycle
    logic region_end;  // that byte closes the region
  } cell_ctrl_t;

endpackage

// ----- design/mbps_cell.sv -----
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic [7:0] byte_in,
  input  logic [7:0] pat_byte,
  input  logic       care,
  output logic       ok,
  output logic [7:0] byte_r
);

  logic [7:0] byte_nxt;

  // this window position agrees with its pattern byte or is a wildcard
  assign ok = ~care | (byte_in == pat_byte);

  // window byte handed to the next cell, cleared at region end
  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.advance) begin
      byte_nxt = ctrl.region_end ? 8'h00 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

endmodule

// ----- design/mbps_obuf.sv -----
module mbps_obuf
  import mbps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  out_t push_data,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  out_t main_r, main_nxt;
  out_t skid_r, skid_nxt;
  logic pop;

  assign pop       = main_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  // two-entry buffer: output register plus skid stage
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ----- design/masked_byte_pattern_scanner.sv -----
// Searches a byte stream for a signature of up to PATTERN_MAX bytes, each byte
// with a care bit (cleared = wildcard), and on the byte flagged last_byte returns
// whether the signature occurred and the start offset of its first occurrence
// (offset saturates at 2^32-1). One byte is taken every clock cycle unless the
// input is stalled: a chain of PATTERN_MAX-1 window cells shifts the recent
// bytes along by one per byte, and every window position is compared in the same
// cycle with the pattern byte lined up for the active length, so the rate does
// not depend on the length. The result is pushed into a two-entry output buffer
// for the output channel when the last byte is taken; the input stalls only
// while both entries are full. Register writes take effect from the next byte
// taken, also in the middle of a region. No clearing pass is needed after reset.
module masked_byte_pattern_scanner
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PAT_IDX_W = $clog2(PATTERN_MAX);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  logic [CFG_DATA_W-1:0] pattern_r [NUM_PAT_REGS];
  logic [CARE_W-1:0]     care_r;
  logic [LEN_W-1:0]      len_r;

  logic [SEEN_W-1:0]   seen_r, seen_nxt;
  logic                first_hit_r, first_hit_nxt;
  logic [OFFSET_W-1:0] first_off_r, first_off_nxt;

  logic                   accept;
  cell_ctrl_t             ctrl;
  logic [7:0]             pat_bytes [PATTERN_MAX];
  logic [7:0]             al_pat [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] al_care;
  logic [7:0]             win_vec [PATTERN_MAX-1];
  logic [PATTERN_MAX-1:0] ok_vec;
  logic [LEN_W-1:0]       len_eff;
  logic [LEN_W-1:0]       len_m1;
  logic                   enough;
  logic                   new_hit;
  logic [SEEN_W-1:0]      start;
  logic [OFFSET_W-1:0]    start_sat;
  logic                   push;
  out_t                   result;
  logic                   buf_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_PAT_REGS; i++) begin
        pattern_r[i] <= '0;
      end
      care_r <= CARE_RESET;
      len_r  <= LEN_RESET;
    end else if (cfg_we) begin
      case (cfg_index) inside
        [REG_PAT_FIRST:REG_PAT_LAST]: pattern_r[cfg_index] <= cfg_data;
        REG_CARE: care_r <= cfg_data[CARE_W-1:0];
        REG_LEN:  len_r  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept          = in_valid & ~in_stall;
  assign ctrl.advance    = accept;
  assign ctrl.region_end = in_data.last_byte;

  // pattern bytes in index order
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
    assign pat_bytes[j] = pattern_r[j/8][(j%8)*8 +: 8];
  end

  // active length, clamped to the maximum
  assign len_eff = (len_r > LEN_MAX) ? LEN_MAX : len_r;
  assign len_m1  = len_eff - LEN_W'(1);

  // pattern byte and care bit lined up with each window position
  always_comb begin
    for (int d = 0; d < PATTERN_MAX; d++) begin
      al_pat[d]  = 8'h00;
      al_care[d] = 1'b0;
      if (LEN_W'(d) < len_eff) begin
        al_pat[d]  = pat_bytes[PAT_IDX_W'(len_m1 - LEN_W'(d))];
        al_care[d] = care_r[PAT_IDX_W'(len_m1 - LEN_W'(d))];
      end
    end
  end

  // chain of window cells, cell k compares the byte k places back
  for (genvar k = 0; k < PATTERN_MAX - 1; k++) begin : g_cell
    logic [7:0] byte_in;
    if (k == 0) begin : g_head
      assign byte_in = in_data.image_byte;
    end else begin : g_link
      assign byte_in = win_vec[k-1];
    end
    mbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .byte_in  (byte_in),
      .pat_byte (al_pat[k]),
      .care     (al_care[k]),
      .ok       (ok_vec[k]),
      .byte_r   (win_vec[k])
    );
  end

  // oldest window position sits past the last cell
  assign ok_vec[PATTERN_MAX-1] = ~al_care[PATTERN_MAX-1] |
                                 (win_vec[PATTERN_MAX-2] == al_pat[PATTERN_MAX-1]);

  // full match once enough bytes of the region have arrived
  assign enough  = (seen_r >= SEEN_W'(len_m1));
  assign new_hit = ~first_hit_r & (len_eff != '0) & enough & (&ok_vec);

  // start offset of the window ending at this byte, saturated to 32 bits
  assign start     = seen_r - SEEN_W'(len_m1);
  assign start_sat = start[SEEN_W-1] ? {OFFSET_W{1'b1}} : start[OFFSET_W-1:0];

  // region counter and first hit record
  always_comb begin
    seen_nxt      = seen_r;
    first_hit_nxt = first_hit_r;
    first_off_nxt = first_off_r;
    if (accept) begin
      if (in_data.last_byte) begin
        seen_nxt      = '0;
        first_hit_nxt = 1'b0;
        first_off_nxt = '0;
      end else begin
        if (seen_r != SEEN_MAX) begin
          seen_nxt = seen_r + SEEN_W'(1);
        end
        if (new_hit) begin
          first_hit_nxt = 1'b1;
          first_off_nxt = start_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      first_hit_r <= 1'b0;
      first_off_r <= '0;
    end else begin
      seen_r      <= seen_nxt;
      first_hit_r <= first_hit_nxt;
      first_off_r <= first_off_nxt;
    end
  end

  // result transaction on the last byte of the region
  assign push               = accept & in_data.last_byte;
  assign result.match_found = first_hit_r | new_hit;
  assign result.match_offset = first_hit_r ? first_off_r :
                               (new_hit ? start_sat : '0);

  mbps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign in_stall = buf_full;

endmodule
